[rtl/core/calendar_date_time_adjuster_assert.svh]
// assertion helpers for the calendar date and time adjuster
`ifndef CALENDAR_DATE_TIME_ADJUSTER_ASSERT_SVH
`define CALENDAR_DATE_TIME_ADJUSTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CDTA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("calendar adjuster check failed");

// next-cycle implication, checked out of reset
`define CDTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("calendar adjuster check failed");

`endif

[rtl/core/cdta_pkg.sv]
package cdta_pkg;

    // working width of second, minute, hour and day counts
    localparam int TW = 17;
    // working width of the month count
    localparam int MW = 13;
    // divisor and remainder width of the shared divider
    localparam int DIV_W = 6;

    // reciprocal multipliers, (x * RECIP) >> SHIFT is exact for any TW-bit count
    localparam int RECIP_W = 18;
    localparam logic [RECIP_W-1:0] RECIP_60 = 18'd139811;
    localparam int                 SHIFT_60 = 23;
    localparam logic [RECIP_W-1:0] RECIP_24 = 18'd174763;
    localparam int                 SHIFT_24 = 22;
    localparam logic [RECIP_W-1:0] RECIP_12 = 18'd174763;
    localparam int                 SHIFT_12 = 21;

    localparam int RESET_YEAR = 1970;

    localparam logic [DIV_W-1:0] SEC_PER_MIN  = 6'd60;
    localparam logic [DIV_W-1:0] MIN_PER_HOUR = 6'd60;
    localparam logic [DIV_W-1:0] HOUR_PER_DAY = 6'd24;
    localparam logic [DIV_W-1:0] MON_PER_YEAR = 6'd12;
    localparam logic [MW-1:0]    LAST_MONTH   = 13'd12;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_ADJUST = 1'b1;

    // field under division
    typedef enum logic [1:0] {
        FLD_SEC  = 2'd0,
        FLD_MIN  = 2'd1,
        FLD_HOUR = 2'd2,
        FLD_MON  = 2'd3
    } field_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   div_start;
        logic   div_take;
        logic   walk;
        logic   publish;
        field_t field;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic walk_more;
        logic out_free;
    } sts_t;

    // month length, month in 1..12
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

[rtl/core/cdta_div.sv]
module cdta_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cdta_pkg::TW-1:0]       dividend,
    input  logic [cdta_pkg::DIV_W-1:0]    divisor,
    output logic [cdta_pkg::TW-1:0]       quot,
    output logic [cdta_pkg::DIV_W-1:0]    rem,
    output logic                          done
);

    localparam int TW = cdta_pkg::TW;
    localparam int RW = cdta_pkg::RECIP_W;
    localparam int DW = cdta_pkg::DIV_W;

    logic [TW-1:0]    num_reg, num_next;
    logic [DW-1:0]    div_reg, div_next;
    logic [TW-1:0]    quot_reg, quot_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic             mul_reg;
    logic             sub_reg;
    logic             done_reg;
    logic [RW-1:0]    recip;
    logic [TW+RW-1:0] prod;
    logic [TW-1:0]    quot_calc;
    logic [TW-1:0]    back;
    logic [TW-1:0]    diff;

    // reciprocal of the divisor, divisors are 60, 24 or 12
    always_comb begin
        case (div_reg)
            cdta_pkg::SEC_PER_MIN: begin
                recip = cdta_pkg::RECIP_60;
            end
            cdta_pkg::HOUR_PER_DAY: begin
                recip = cdta_pkg::RECIP_24;
            end
            default: begin
                recip = cdta_pkg::RECIP_12;
            end
        endcase
    end

    // first step: quotient from one multiply and a fixed shift
    assign prod = {{RW{1'b0}}, num_reg} * {{TW{1'b0}}, recip};

    always_comb begin
        case (div_reg)
            cdta_pkg::SEC_PER_MIN: begin
                quot_calc = TW'(prod >> cdta_pkg::SHIFT_60);
            end
            cdta_pkg::HOUR_PER_DAY: begin
                quot_calc = TW'(prod >> cdta_pkg::SHIFT_24);
            end
            default: begin
                quot_calc = TW'(prod >> cdta_pkg::SHIFT_12);
            end
        endcase
    end

    // second step: remainder from the registered quotient
    assign back = quot_reg * {{(TW-DW){1'b0}}, div_reg};
    assign diff = num_reg - back;

    always_comb begin
        num_next  = num_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            num_next = dividend;
            div_next = divisor;
        end
        if (mul_reg) begin
            quot_next = quot_calc;
        end
        if (sub_reg) begin
            rem_next = diff[DW-1:0];
        end
    end

    // stage flags: multiply, subtract, result ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= start;
            sub_reg  <= mul_reg;
            done_reg <= sub_reg;
        end
    end

    // operands and partial results
    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

[rtl/core/cdta_datapath.sv]
module cdta_datapath #(
    parameter int YEAR_BITS   = 14,
    parameter int OFFSET_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cdta_pkg::cmd_t       cmd,
    output cdta_pkg::sts_t       sts,
    input  logic                 action,
    input  logic [13:0]          year_value,
    input  logic [11:0]          month_value,
    input  logic [15:0]          day_value,
    input  logic [15:0]          hour_value,
    input  logic [15:0]          minute_value,
    input  logic [15:0]          second_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [13:0]          year_out,
    output logic [3:0]           month_out,
    output logic [4:0]           day_out,
    output logic [4:0]           hour_out,
    output logic [5:0]           minute_out,
    output logic [5:0]           second_out,
    output logic                 year_wrapped
);

    localparam int TW = cdta_pkg::TW;
    localparam int MW = cdta_pkg::MW;
    // year count holds the widest load plus all carries before the wrap
    localparam int YW = ((YEAR_BITS > 14) ? YEAR_BITS : 14) + 2;
    localparam int OB = (OFFSET_BITS > 16) ? 16 : OFFSET_BITS;
    localparam logic [15:0]   OMASK  = 16'((33'd1 << OB) - 33'd1);
    localparam logic [YW-1:0] YMASK  = YW'((64'd1 << YEAR_BITS) - 64'd1);
    localparam logic [YW-1:0] Y_RST  = YW'(cdta_pkg::RESET_YEAR);
    localparam logic [MW-1:0] MO_ONE = MW'(1);
    localparam logic [TW-1:0] D_ONE  = TW'(1);

    logic [YW-1:0] y_reg, y_next;
    logic [MW-1:0] mo_reg, mo_next;
    logic [TW-1:0] d_reg, d_next;
    logic [TW-1:0] h_reg, h_next;
    logic [TW-1:0] mi_reg, mi_next;
    logic [TW-1:0] s_reg, s_next;

    logic                       out_valid_reg;
    logic [13:0]                out_year_reg;
    logic [3:0]                 out_month_reg;
    logic [4:0]                 out_day_reg;
    logic [4:0]                 out_hour_reg;
    logic [5:0]                 out_minute_reg;
    logic [5:0]                 out_second_reg;
    logic                       out_wrap_reg;

    logic [TW-1:0]                div_dividend;
    logic [cdta_pkg::DIV_W-1:0]   div_divisor;
    logic [TW-1:0]                div_quot;
    logic [cdta_pkg::DIV_W-1:0]   div_rem;
    logic                         div_done;
    logic [MW-1:0]                mo_m1;
    logic [4:0]                   dim;
    logic [YW-1:0]                y_masked;

    assign mo_m1    = mo_reg - MO_ONE;
    assign dim      = cdta_pkg::days_in(mo_reg[3:0], y_reg[1:0] == 2'b00);
    assign y_masked = y_reg & YMASK;

    // divider operand select
    always_comb begin
        case (cmd.field)
            cdta_pkg::FLD_SEC: begin
                div_dividend = s_reg;
                div_divisor  = cdta_pkg::SEC_PER_MIN;
            end
            cdta_pkg::FLD_MIN: begin
                div_dividend = mi_reg;
                div_divisor  = cdta_pkg::MIN_PER_HOUR;
            end
            cdta_pkg::FLD_HOUR: begin
                div_dividend = h_reg;
                div_divisor  = cdta_pkg::HOUR_PER_DAY;
            end
            default: begin
                div_dividend = {{(TW-MW){1'b0}}, mo_m1};
                div_divisor  = cdta_pkg::MON_PER_YEAR;
            end
        endcase
    end

    cdta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    // working date and time, doubles as the held state between items
    always_comb begin
        y_next  = y_reg;
        mo_next = mo_reg;
        d_next  = d_reg;
        h_next  = h_reg;
        mi_next = mi_reg;
        s_next  = s_reg;
        if (cmd.load) begin
            if (action == cdta_pkg::ACT_LOAD) begin
                y_next  = YW'(year_value);
                mo_next = (month_value == 12'd0) ? MO_ONE : {1'b0, month_value};
                d_next  = (day_value == 16'd0) ? D_ONE : {1'b0, day_value};
                h_next  = {1'b0, hour_value};
                mi_next = {1'b0, minute_value};
                s_next  = {1'b0, second_value};
            end else begin
                y_next  = y_reg + YW'(year_value & OMASK[13:0]);
                mo_next = mo_reg + {1'b0, month_value & OMASK[11:0]};
                d_next  = d_reg + {1'b0, day_value & OMASK};
                h_next  = h_reg + {1'b0, hour_value & OMASK};
                mi_next = mi_reg + {1'b0, minute_value & OMASK};
                s_next  = s_reg + {1'b0, second_value & OMASK};
            end
        end else if (cmd.div_take) begin
            case (cmd.field)
                cdta_pkg::FLD_SEC: begin
                    s_next  = {{(TW-cdta_pkg::DIV_W){1'b0}}, div_rem};
                    mi_next = mi_reg + div_quot;
                end
                cdta_pkg::FLD_MIN: begin
                    mi_next = {{(TW-cdta_pkg::DIV_W){1'b0}}, div_rem};
                    h_next  = h_reg + div_quot;
                end
                cdta_pkg::FLD_HOUR: begin
                    h_next = {{(TW-cdta_pkg::DIV_W){1'b0}}, div_rem};
                    d_next = d_reg + div_quot;
                end
                default: begin
                    mo_next = {{(MW-cdta_pkg::DIV_W){1'b0}}, div_rem} + MO_ONE;
                    y_next  = y_reg + YW'(div_quot);
                end
            endcase
        end else if (cmd.walk) begin
            // one month of day carry
            d_next = d_reg - {{(TW-5){1'b0}}, dim};
            if (mo_reg == cdta_pkg::LAST_MONTH) begin
                mo_next = MO_ONE;
                y_next  = y_reg + YW'(1);
            end else begin
                mo_next = mo_reg + MO_ONE;
            end
        end else if (cmd.publish) begin
            y_next = y_masked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg  <= Y_RST;
            mo_reg <= MO_ONE;
            d_reg  <= D_ONE;
            h_reg  <= '0;
            mi_reg <= '0;
            s_reg  <= '0;
        end else begin
            y_reg  <= y_next;
            mo_reg <= mo_next;
            d_reg  <= d_next;
            h_reg  <= h_next;
            mi_reg <= mi_next;
            s_reg  <= s_next;
        end
    end

    // result register, held until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_year_reg   <= y_masked[13:0];
            out_month_reg  <= mo_reg[3:0];
            out_day_reg    <= d_reg[4:0];
            out_hour_reg   <= h_reg[4:0];
            out_minute_reg <= mi_reg[5:0];
            out_second_reg <= s_reg[5:0];
            out_wrap_reg   <= ((y_reg & ~YMASK) != '0);
        end
    end

    assign sts.div_done  = div_done;
    assign sts.walk_more = (d_reg > {{(TW-5){1'b0}}, dim});
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign year_out     = out_year_reg;
    assign month_out    = out_month_reg;
    assign day_out      = out_day_reg;
    assign hour_out     = out_hour_reg;
    assign minute_out   = out_minute_reg;
    assign second_out   = out_second_reg;
    assign year_wrapped = out_wrap_reg;

endmodule

[rtl/core/cdta_ctrl.sv]
module cdta_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_accept,
    input  cdta_pkg::sts_t sts,
    output cdta_pkg::cmd_t cmd,
    output logic           in_ready
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DIV_GO  = 5'b00010,
        ST_DIV_RUN = 5'b00100,
        ST_WALK    = 5'b01000,
        ST_FIN     = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    cdta_pkg::field_t  field_reg, field_next;

    // sequence: seconds, minutes, hours, months through the divider, then month walk and publish
    always_comb begin
        state_next    = state_reg;
        field_next    = field_reg;
        cmd           = '0;
        cmd.field     = field_reg;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    cmd.load   = 1'b1;
                    field_next = cdta_pkg::FLD_SEC;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    case (field_reg)
                        cdta_pkg::FLD_SEC: begin
                            field_next = cdta_pkg::FLD_MIN;
                            state_next = ST_DIV_GO;
                        end
                        cdta_pkg::FLD_MIN: begin
                            field_next = cdta_pkg::FLD_HOUR;
                            state_next = ST_DIV_GO;
                        end
                        cdta_pkg::FLD_HOUR: begin
                            field_next = cdta_pkg::FLD_MON;
                            state_next = ST_DIV_GO;
                        end
                        default: begin
                            state_next = ST_WALK;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (sts.walk_more) begin
                    cmd.walk = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            field_reg <= cdta_pkg::FLD_SEC;
        end else begin
            state_reg <= state_next;
            field_reg <= field_next;
        end
    end

endmodule

[rtl/core/calendar_date_time_adjuster.sv]
// channel   dir  tdata (low bit up)                                  tuser
// s_        in   year 14, month 12, day 16, hour 16, minute 16,       action
//                second 16, zero pad to 96
// m_        out  year 14, month 4, day 5, hour 5, minute 6, second 6  year_wrapped
//
// an item passes from input to result through the shared divider
// (seconds, minutes, hours, months in turn), then one walk step per month
// boundary crossed by the day carry.
// aresetn is synchronous; reset sets 1970-01-01 00:00:00.
// one item at a time; the next item is taken while a result waits on m_tready.
`include "calendar_date_time_adjuster_assert.svh"

module calendar_date_time_adjuster #(
    parameter int YEAR_BITS   = 14,
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_value, month_value, day_value, hour_value, minute_value, second_value
    input  logic [95:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // year_out, month_out, day_out, hour_out, minute_out, second_out
    output logic [39:0] m_tdata,
    // year_wrapped
    output logic        m_tuser
);

    cdta_pkg::cmd_t cmd;
    cdta_pkg::sts_t sts;
    logic           in_accept;

    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;

    assign in_accept = s_tvalid && s_tready;

    cdta_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready)
    );

    cdta_datapath #(
        .YEAR_BITS   (YEAR_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .action       (s_tuser),
        .year_value   (s_tdata[13:0]),
        .month_value  (s_tdata[25:14]),
        .day_value    (s_tdata[41:26]),
        .hour_value   (s_tdata[57:42]),
        .minute_value (s_tdata[73:58]),
        .second_value (s_tdata[89:74]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .year_out     (year_out),
        .month_out    (month_out),
        .day_out      (day_out),
        .hour_out     (hour_out),
        .minute_out   (minute_out),
        .second_out   (second_out),
        .year_wrapped (m_tuser)
    );

    // result packing
    assign m_tdata = {second_out, minute_out, hour_out, day_out, month_out, year_out};

    // normalized fields stay in calendar range
    `CDTA_ASSERT_NOW(a_month_range, m_tvalid, (month_out != 4'd0) && (month_out <= 4'd12))
    `CDTA_ASSERT_NOW(a_day_nonzero, m_tvalid, day_out != 5'd0)
    `CDTA_ASSERT_NOW(a_hour_range, m_tvalid, hour_out < 5'd24)
    `CDTA_ASSERT_NOW(a_min_sec_range, m_tvalid, (minute_out < 6'd60) && (second_out < 6'd60))
    // an accepted item never finishes in the following cycle
    `CDTA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule
